/* hw/rtl/tcc_pkg.sv */
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int COLS_CAP = 256;
	localparam int ROWS_CAP = 128;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [1:0] KIND_DRAW   = 2'd0;
	localparam logic [1:0] KIND_SCROLL = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [1:0] REG_ENABLE       = 2'd0;
	localparam logic [1:0] REG_CELLS_ACROSS = 2'd1;
	localparam logic [1:0] REG_CELLS_DOWN   = 2'd2;
	localparam logic [1:0] REG_BACK_COLOR   = 2'd3;

	localparam logic [8:0] RST_CELLS_ACROSS = 9'd128;
	localparam logic [7:0] RST_CELLS_DOWN   = 8'd48;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  cell_col;
		logic [6:0]  cell_row;
		logic [7:0]  glyph_code;
		logic [31:0] draw_fore;
		logic [31:0] draw_back;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] col;
		logic [6:0] row;
	} cursor_t;

	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  r0;
		out_item_t  r1;
		cursor_t    cur_nxt;
	} step_res_t;

endpackage

/* hw/rtl/tcc_in_if.sv */
`timescale 1ns / 1ps

interface tcc_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  char_code;
	logic [31:0] fore_color;

	modport source (output valid, output cmd, output char_code, output fore_color,
		input ready);
	modport sink (input valid, input cmd, input char_code, input fore_color,
		output ready);
endinterface

/* hw/rtl/tcc_out_if.sv */
`timescale 1ns / 1ps

interface tcc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  cell_col;
	logic [6:0]  cell_row;
	logic [7:0]  glyph_code;
	logic [31:0] draw_fore;
	logic [31:0] draw_back;
	logic        last;

	modport source (output valid, output kind, output cell_col, output cell_row,
		output glyph_code, output draw_fore, output draw_back, output last,
		input ready);
	modport sink (input valid, input kind, input cell_col, input cell_row,
		input glyph_code, input draw_fore, input draw_back, input last,
		output ready);
endinterface

/* hw/rtl/tcc_step.sv */
`timescale 1ns / 1ps

module tcc_step (
	input  logic                enable,
	input  logic                cmd,
	input  logic [7:0]          char_code,
	input  logic [31:0]         fore_color,
	input  tcc_pkg::cursor_t    cur,
	input  logic [8:0]          cells_across,
	input  logic [7:0]          cells_down,
	input  logic [31:0]         back_color,
	output tcc_pkg::step_res_t  res
);

	always_comb begin
		logic [9:0] cols_eff;
		logic [7:0] rows_eff;
		logic [9:0] col;
		logic [7:0] row;
		logic       drew;
		logic       scroll;
		tcc_pkg::out_item_t draw_r;
		tcc_pkg::out_item_t scr_r;

		// saturate the screen size to what the cursor can address
		if (cells_across == 9'd0) begin
			cols_eff = 10'd1;
		end else if ({1'b0, cells_across} > 10'(tcc_pkg::COLS_CAP)) begin
			cols_eff = 10'(tcc_pkg::COLS_CAP);
		end else begin
			cols_eff = {1'b0, cells_across};
		end
		if (cells_down == 8'd0) begin
			rows_eff = 8'd1;
		end else if (cells_down > 8'(tcc_pkg::ROWS_CAP)) begin
			rows_eff = 8'(tcc_pkg::ROWS_CAP);
		end else begin
			rows_eff = cells_down;
		end

		col  = {2'b00, cur.col};
		row  = {1'b0, cur.row};
		drew = 1'b0;

		draw_r.kind       = tcc_pkg::KIND_DRAW;
		draw_r.cell_col   = cur.col;
		draw_r.cell_row   = cur.row;
		draw_r.glyph_code = char_code;
		draw_r.draw_fore  = fore_color;
		draw_r.draw_back  = back_color;
		draw_r.last       = 1'b0;

		case (char_code)
			tcc_pkg::CH_NL: begin
				col = 10'd0;
				row = row + 8'd1;
			end
			tcc_pkg::CH_CR: begin
				col = 10'd0;
			end
			tcc_pkg::CH_BS: begin
				// erase the previous cell unless already at the left edge
				if (col != 10'd0) begin
					col = col - 10'd1;
					drew = 1'b1;
					draw_r.cell_col   = col[7:0];
					draw_r.glyph_code = tcc_pkg::CH_SPACE;
					draw_r.draw_fore  = back_color;
				end
			end
			tcc_pkg::CH_TAB: begin
				col = (col + 10'd4) & 10'h3FC;
			end
			default: begin
				drew = 1'b1;
				col  = col + 10'd1;
			end
		endcase

		if (col >= cols_eff) begin
			col = 10'd0;
			row = row + 8'd1;
		end
		scroll = (row >= rows_eff);
		if (scroll) begin
			row = rows_eff - 8'd1;
		end

		scr_r.kind       = tcc_pkg::KIND_SCROLL;
		scr_r.cell_col   = 8'd0;
		scr_r.cell_row   = 7'd0;
		scr_r.glyph_code = 8'd0;
		scr_r.draw_fore  = 32'd0;
		scr_r.draw_back  = back_color;
		scr_r.last       = 1'b1;

		res.r1 = scr_r;
		if (!enable) begin
			res.cnt     = 2'd0;
			res.r0      = scr_r;
			res.cur_nxt = cur;
		end else if (cmd) begin
			res.cnt     = 2'd1;
			res.r0      = scr_r;
			res.r0.kind = tcc_pkg::KIND_CLEAR;
			res.cur_nxt = '0;
		end else begin
			res.cnt         = {1'b0, drew} + {1'b0, scroll};
			res.r0          = drew ? draw_r : scr_r;
			res.r0.last     = !(drew && scroll);
			res.cur_nxt.col = col[7:0];
			res.cur_nxt.row = row[6:0];
		end
	end

endmodule

/* hw/rtl/tcc_out_queue.sv */
`timescale 1ns / 1ps

module tcc_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  tcc_pkg::out_item_t  r0,
	input  tcc_pkg::out_item_t  r1,
	output logic                room,
	tcc_out_if.source           draw
);

	localparam int PW = $clog2(tcc_pkg::QUEUE_DEPTH);

	tcc_pkg::out_item_t mem_q [tcc_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   count_q;
	logic          pop;

	assign pop  = draw.valid && draw.ready;
	// two free slots cover the worst case of one item
	assign room = count_q <= (PW+1)'(tcc_pkg::QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wptr_q] <= r0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wptr_q + PW'(1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PW'(push_cnt);
			rptr_q  <= rptr_q + PW'(pop);
			count_q <= count_q + (PW+1)'(push_cnt) - (PW+1)'(pop);
		end
	end

	assign draw.valid      = count_q != '0;
	assign draw.kind       = mem_q[rptr_q].kind;
	assign draw.cell_col   = mem_q[rptr_q].cell_col;
	assign draw.cell_row   = mem_q[rptr_q].cell_row;
	assign draw.glyph_code = mem_q[rptr_q].glyph_code;
	assign draw.draw_fore  = mem_q[rptr_q].draw_fore;
	assign draw.draw_back  = mem_q[rptr_q].draw_back;
	assign draw.last       = mem_q[rptr_q].last;

endmodule

/* hw/rtl/text_console_cursor_engine_unit.sv */
`timescale 1ns / 1ps
// Text console cursor engine.
// console: one item per event, either a character with its foreground color
//   or a clear-screen request (cmd high). draw: drawing commands (draw cell,
//   scroll one text row, clear screen), up to two per event, the final one
//   flagged by last. Both channels move an item when valid and ready are high.
// Configuration: cfg_we writes cfg_data into register cfg_index (enable,
//   cells_across, cells_down, back_color); write only while the block is idle.
// An accepted item is held in the input register; its results enter a
//   four-entry output queue once the queue has room and show on draw from
//   the queue. Throughput is one item per cycle while the queue has two
//   free slots; an event that yields two results needs two transfers on
//   draw, so a run of such events is paced by the draw side.
// While disabled, items are taken and dropped without changing the cursor.
// Reset clears the cursor to the top left, empties the queue and loads the
//   register defaults (disabled, 128 columns, 48 rows, black background).
// When draw stalls, the queue fills and console.ready drops once fewer than
//   two slots are free with an item in the input register; nothing is lost.

module text_console_cursor_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	tcc_in_if.sink      console,
	tcc_out_if.source   draw
);

	logic        enable_q;
	logic [8:0]  cells_across_q;
	logic [7:0]  cells_down_q;
	logic [31:0] back_color_q;

	tcc_pkg::cursor_t cursor_q;

	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  char_s1;
	logic [31:0] fore_s1;

	tcc_pkg::step_res_t res;
	logic room;
	logic advance;
	logic take;

	assign advance       = valid_s1 && room;
	assign console.ready = !valid_s1 || room;
	assign take          = console.valid && console.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			cells_across_q <= tcc_pkg::RST_CELLS_ACROSS;
			cells_down_q   <= tcc_pkg::RST_CELLS_DOWN;
			back_color_q   <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				tcc_pkg::REG_ENABLE:       enable_q       <= cfg_data[0];
				tcc_pkg::REG_CELLS_ACROSS: cells_across_q <= cfg_data[8:0];
				tcc_pkg::REG_CELLS_DOWN:   cells_down_q   <= cfg_data[7:0];
				tcc_pkg::REG_BACK_COLOR:   back_color_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cursor_q <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				cursor_q <= res.cur_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= console.cmd;
			char_s1 <= console.char_code;
			fore_s1 <= console.fore_color;
		end
	end

	tcc_step u_step (
		.enable       (enable_q),
		.cmd          (cmd_s1),
		.char_code    (char_s1),
		.fore_color   (fore_s1),
		.cur          (cursor_q),
		.cells_across (cells_across_q),
		.cells_down   (cells_down_q),
		.back_color   (back_color_q),
		.res          (res)
	);

	tcc_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (advance ? res.cnt : 2'd0),
		.r0       (res.r0),
		.r1       (res.r1),
		.room     (room),
		.draw     (draw)
	);

	a_disabled_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |-> res.cnt == 2'd0)
		else $error("disabled block produced results");

	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && enable_q && cmd_s1 |=> cursor_q == '0)
		else $error("clear did not home the cursor");

	a_hold_without_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cursor_q))
		else $error("cursor moved without an item");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!console.ready |-> valid_s1 && !room)
		else $error("input stalled with a free slot");

	a_second_is_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		res.cnt == 2'd2 |-> res.r0.kind == tcc_pkg::KIND_DRAW && !res.r0.last)
		else $error("two results not draw then scroll");

endmodule

/* dv/text_console_cursor_engine_unit_tb.sv */
`timescale 1ns / 1ps

module text_console_cursor_engine_unit_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 300;

	// Tracks the cursor and register copy, and predicts the draw commands of each event.
	class cursor_tracker;
		logic        enable_r;
		logic [8:0]  across_r;
		logic [7:0]  down_r;
		logic [31:0] back_r;
		int unsigned cur_col;
		int unsigned cur_row;
		tcc_pkg::out_item_t pending_draws[$];
		int          mismatches;

		function new();
			enable_r = 1'b0;
			across_r = tcc_pkg::RST_CELLS_ACROSS;
			down_r = tcc_pkg::RST_CELLS_DOWN;
			back_r = '0;
			cur_col = 0;
			cur_row = 0;
			mismatches = 0;
		endfunction

		function void load_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				tcc_pkg::REG_ENABLE:       enable_r = val[0];
				tcc_pkg::REG_CELLS_ACROSS: across_r = val[8:0];
				tcc_pkg::REG_CELLS_DOWN:   down_r = val[7:0];
				tcc_pkg::REG_BACK_COLOR:   back_r = val;
				default: ;
			endcase
		endfunction

		function tcc_pkg::out_item_t draw_cmd(logic [1:0] kind, int unsigned col,
			int unsigned row, logic [7:0] glyph, logic [31:0] fore);
			tcc_pkg::out_item_t r;
			r.kind = kind;
			r.cell_col = col[7:0];
			r.cell_row = row[6:0];
			r.glyph_code = glyph;
			r.draw_fore = fore;
			r.draw_back = back_r;
			r.last = 1'b0;
			return r;
		endfunction

		function void take_event(logic cmd, logic [7:0] ch, logic [31:0] fore);
			tcc_pkg::out_item_t fresh[$];
			int unsigned cols, rows, col, row;
			if (!enable_r)
				return;
			if (cmd) begin
				fresh.push_back(draw_cmd(tcc_pkg::KIND_CLEAR, 0, 0, 8'd0, 32'd0));
				cur_col = 0;
				cur_row = 0;
			end else begin
				cols = (across_r == 0) ? 1 :
					((across_r > tcc_pkg::COLS_CAP) ? tcc_pkg::COLS_CAP : across_r);
				rows = (down_r == 0) ? 1 :
					((down_r > tcc_pkg::ROWS_CAP) ? tcc_pkg::ROWS_CAP : down_r);
				col = cur_col;
				row = cur_row;
				if (ch == tcc_pkg::CH_NL) begin
					col = 0;
					row = row + 1;
				end else if (ch == tcc_pkg::CH_CR) begin
					col = 0;
				end else if (ch == tcc_pkg::CH_BS) begin
					// erase the previous cell only when there is one
					if (col > 0) begin
						col = col - 1;
						fresh.push_back(draw_cmd(tcc_pkg::KIND_DRAW, col, row,
							tcc_pkg::CH_SPACE, back_r));
					end
				end else if (ch == tcc_pkg::CH_TAB) begin
					col = (col + 4) & ~32'd3;
				end else begin
					fresh.push_back(draw_cmd(tcc_pkg::KIND_DRAW, col, row, ch, fore));
					col = col + 1;
				end
				if (col >= cols) begin
					col = 0;
					row = row + 1;
				end
				if (row >= rows) begin
					fresh.push_back(draw_cmd(tcc_pkg::KIND_SCROLL, 0, 0, 8'd0, 32'd0));
					row = rows - 1;
				end
				cur_col = col & 32'hFF;
				cur_row = row & 32'h7F;
			end
			foreach (fresh[i]) begin
				if (i == fresh.size() - 1)
					fresh[i].last = 1'b1;
				pending_draws.push_back(fresh[i]);
			end
		endfunction

		function void check(string field, logic [31:0] want_v, logic [31:0] got_v);
			if (want_v !== got_v) begin
				$error("%s: expected %0h, got %0h", field, want_v, got_v);
				mismatches++;
			end
		endfunction

		function void match_draw(tcc_pkg::out_item_t got);
			tcc_pkg::out_item_t want;
			if (pending_draws.size() == 0) begin
				$error("draw item with none expected: kind %0d col %0d row %0d",
					got.kind, got.cell_col, got.cell_row);
				mismatches++;
				return;
			end
			want = pending_draws.pop_front();
			check("kind", 32'(want.kind), 32'(got.kind));
			check("cell_col", 32'(want.cell_col), 32'(got.cell_col));
			check("cell_row", 32'(want.cell_row), 32'(got.cell_row));
			check("glyph_code", 32'(want.glyph_code), 32'(got.glyph_code));
			check("draw_fore", want.draw_fore, got.draw_fore);
			check("draw_back", want.draw_back, got.draw_back);
			check("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	bit          hold_draw;
	int unsigned cycle_count;

	cursor_tracker tracker = new();

	tcc_in_if  console_ch();
	tcc_out_if draw_ch();

	text_console_cursor_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.console(console_ch),
		.draw(draw_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (console_ch.valid === 1'b1 && console_ch.ready === 1'b1)
			tracker.take_event(console_ch.cmd, console_ch.char_code, console_ch.fore_color);
	end

	always @(posedge clk) begin : watch_draw
		tcc_pkg::out_item_t got;
		if (draw_ch.valid === 1'b1 && draw_ch.ready === 1'b1) begin
			got.kind = draw_ch.kind;
			got.cell_col = draw_ch.cell_col;
			got.cell_row = draw_ch.cell_row;
			got.glyph_code = draw_ch.glyph_code;
			got.draw_fore = draw_ch.draw_fore;
			got.draw_back = draw_ch.draw_back;
			got.last = draw_ch.last;
			tracker.match_draw(got);
		end
	end

	// Draw side: alternate always-ready, random and sparse stretches; honor a long hold request.
	initial begin : draw_sink
		int mode, span, n;
		draw_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 60);
			for (n = 0; n < span; n++) begin
				if (hold_draw)
					break;
				case (mode)
					0: draw_ch.ready <= 1'b1;
					1: draw_ch.ready <= ($urandom_range(0, 1) == 1);
					default: draw_ch.ready <= ((n % 4) == 0);
				endcase
				@(posedge clk);
			end
			if (hold_draw) begin
				for (n = 0; n < LONG_HOLD_CYCLES; n++) begin
					draw_ch.ready <= 1'b0;
					@(posedge clk);
				end
				hold_draw = 1'b0;
			end
		end
	end

	task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [31:0] fore);
		console_ch.valid <= 1'b1;
		console_ch.cmd <= cmd;
		console_ch.char_code <= ch;
		console_ch.fore_color <= fore;
		do @(posedge clk); while (console_ch.ready !== 1'b1);
	endtask

	task automatic pause_console(input int cycles);
		console_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every predicted draw command has come back, then let the block settle.
	task automatic drain_draws();
		console_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_draws.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tracker.load_reg(idx, val);
	endtask

	// Upper data bits carry noise; only the register's own width counts.
	task automatic setup_screen(input logic en, input logic [8:0] across, input logic [7:0] down,
		input logic [31:0] back);
		set_reg(tcc_pkg::REG_ENABLE, ($urandom & 32'hFFFF_FFFE) | {31'd0, en});
		set_reg(tcc_pkg::REG_CELLS_ACROSS, ($urandom & 32'hFFFF_FE00) | {23'd0, across});
		set_reg(tcc_pkg::REG_CELLS_DOWN, ($urandom & 32'hFFFF_FF00) | {24'd0, down});
		set_reg(tcc_pkg::REG_BACK_COLOR, back);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic        en, cmd;
		logic [8:0]  across;
		logic [7:0]  down, ch;
		logic [31:0] back, fore;
		int          p, k, count, burst, gap, pick;

		arst_n = 1'b0;
		cycle_count = 0;
		hold_draw = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= tcc_pkg::REG_ENABLE;
		cfg_data <= '0;
		console_ch.valid <= 1'b0;
		console_ch.cmd <= 1'b0;
		console_ch.char_code <= '0;
		console_ch.fore_color <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: everything is dropped, clear too
		send_item(1'b1, 8'h41, 32'h1234_5678);
		send_item(1'b0, 8'h78, 32'hFFFF_FFFF);
		send_item(1'b0, tcc_pkg::CH_NL, 32'd0);
		drain_draws();

		// reset geometry, enable only
		set_reg(tcc_pkg::REG_ENABLE, 32'd1);
		cfg_we <= 1'b0;
		send_item(1'b1, 8'hFF, 32'hFFFF_FFFF);
		send_item(1'b0, 8'h00, 32'h0000_0000);
		send_item(1'b0, 8'hFF, 32'hFFFF_FFFF);
		send_item(1'b0, tcc_pkg::CH_BS, 32'hAAAA_5555);
		send_item(1'b0, tcc_pkg::CH_BS, 32'h5555_AAAA);
		send_item(1'b0, tcc_pkg::CH_BS, 32'h0F0F_0F0F);
		send_item(1'b0, tcc_pkg::CH_TAB, 32'd0);
		send_item(1'b0, 8'h61, 32'h00FF_00FF);
		send_item(1'b0, tcc_pkg::CH_TAB, 32'd0);
		send_item(1'b0, tcc_pkg::CH_CR, 32'd0);
		send_item(1'b0, tcc_pkg::CH_NL, 32'd0);
		drain_draws();

		// tiny screen: wrap, scroll on newline, scroll on tab, draw plus scroll
		setup_screen(1'b1, 9'd4, 8'd2, 32'hFFFF_FFFF);
		send_item(1'b1, 8'h00, 32'd0);
		for (k = 0; k < 4; k++)
			send_item(1'b0, 8'h30 + k[7:0], $urandom);
		send_item(1'b0, tcc_pkg::CH_NL, 32'd0);
		send_item(1'b0, tcc_pkg::CH_TAB, 32'd0);
		for (k = 0; k < 4; k++)
			send_item(1'b0, 8'h80 + k[7:0], $urandom);
		drain_draws();

		for (p = 0; p < 12; p++) begin
			en = (p != 4);
			case ($urandom_range(0, 7))
				0: across = 9'd1;
				1: across = 9'd256;
				2: across = 9'd0;
				3: across = 9'd511;
				4: across = 9'd257;
				5, 6: across = 9'($urandom_range(2, 8));
				default: across = 9'($urandom_range(1, 511));
			endcase
			case ($urandom_range(0, 7))
				0: down = 8'd1;
				1: down = 8'd128;
				2: down = 8'd0;
				3: down = 8'd255;
				4: down = 8'd129;
				5, 6: down = 8'($urandom_range(2, 6));
				default: down = 8'($urandom_range(1, 255));
			endcase
			case (p)
				0: begin across = 9'd256; down = 8'd128; end
				1: begin across = 9'd1; down = 8'd1; end
				2: begin across = 9'd511; down = 8'd255; end
				3: begin across = 9'd0; down = 8'd0; end
				default: ;
			endcase
			case ($urandom_range(0, 3))
				0: back = 32'd0;
				1: back = 32'hFFFF_FFFF;
				default: back = $urandom;
			endcase
			setup_screen(en, across, down, back);

			// fill the block against a stalled draw side in one phase
			if (p == 6)
				hold_draw = 1'b1;
			count = en ? 68 : 30;
			k = 0;
			while (k < count) begin
				burst = $urandom_range(1, 16);
				for (int b = 0; b < burst && k < count; b++) begin
					cmd = ($urandom_range(0, 99) < 3);
					pick = $urandom_range(0, 99);
					if (pick < 50)
						ch = 8'($urandom);
					else if (pick < 62)
						ch = tcc_pkg::CH_NL;
					else if (pick < 70)
						ch = tcc_pkg::CH_CR;
					else if (pick < 82)
						ch = tcc_pkg::CH_BS;
					else if (pick < 94)
						ch = tcc_pkg::CH_TAB;
					else
						ch = 8'($urandom_range(32, 126));
					fore = $urandom;
					send_item(cmd, ch, fore);
					k++;
				end
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (p == 6 && k < 40)
					gap = 0;
				if (gap > 0)
					pause_console(gap);
			end
			drain_draws();
		end

		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_draws.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
